### src/pim_pkg.sv
// pim_pkg: shared types and constants for the pwm input capture meter
// no dependencies; imported by pim_div, pim_dp, pim_ctrl and the top level
`default_nettype none

package pim_pkg;

    // event codes
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_OVERFLOW = 2'd0;
    localparam opcode_t OP_RISE     = 2'd1;
    localparam opcode_t OP_FALL     = 2'd2;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DUTY_W    = 7;
    localparam int unsigned CAP_IN_W  = 16;
    localparam int unsigned PROD_W    = WORD_W + DUTY_W;   // high_ticks * 100
    localparam int unsigned STEP_W    = 6;                 // holds WORD_W

    localparam logic [WORD_W-1:0] CLOCK_HZ_RESET = 32'd48000000;
    localparam logic [DUTY_W-1:0] DUTY_FULL      = 7'd100;
    localparam logic [WORD_W-1:0] TICK_MAX       = 32'hFFFF_FFFF;

    // divider step counts
    localparam logic [STEP_W-1:0] STEPS_FREQ = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_DUTY = 6'd7;

    // controller to datapath
    typedef struct packed {
        logic capture;      // apply the accepted event to the state
        logic prep;         // register high_ticks * 100
        logic start_duty;   // launch the duty division
        logic save_duty;    // keep the duty result
        logic start_freq;   // launch the frequency division
        logic load_out;     // fill the output register
    } pim_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;         // last event produces a result
        logic clamp;        // high time not below period
        logic div_busy;
        logic out_free;     // output register can take a result
    } pim_status_t;

endpackage

`default_nettype wire

### src/pwm_input_capture_meter.sv
// pwm_input_capture_meter: top level, pwm period/high-time meter from timer events
// depends on pim_pkg, pim_ctrl, pim_dp (and pim_div below it)
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  ---------------------------------------------
// in        sink       in_valid / in_stall  opcode, capture_value
// out       source     out_valid/out_stall  duty_percent, frequency_hz, measurement_count
// cfg       sink       cfg_write_en         cfg_write_data (clock_hz)
//
// one event at a time; a transaction that yields no result frees the input once the check state returns to idle
// a result is dominated by the shared restoring divider: 7 steps for duty (skipped when the
// duty clamps to 100), then 32 steps for clock_hz / period
// the finished result sits in an output register, so the next event is taken while it waits
// asynchronous active-low reset clears all measurement state; clock_hz returns to 48 MHz
`default_nettype none

module pwm_input_capture_meter
#(
    parameter int unsigned CAPTURE_BITS  = 16,   // timer counter width, 8..32
    parameter int unsigned OVERFLOW_BITS = 16    // overflow counter width, 4..32
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write_en,
    input  wire logic [pim_pkg::WORD_W-1:0]      cfg_write_data,
    // event input
    input  wire logic                            in_valid,
    output      logic                            in_stall,
    input  wire pim_pkg::opcode_t                opcode,
    input  wire logic [pim_pkg::CAP_IN_W-1:0]    capture_value,
    // measurement output
    output      logic                            out_valid,
    input  wire logic                            out_stall,
    output      logic [pim_pkg::DUTY_W-1:0]      duty_percent,
    output      logic [pim_pkg::WORD_W-1:0]      frequency_hz,
    output      logic [pim_pkg::WORD_W-1:0]      measurement_count
);
    import pim_pkg::*;

    pim_cmd_t    cmd;
    pim_status_t status;

    // sequencer: accepts an event only when the previous one is fully processed
    pim_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: overflow/period/high state, divider and output register
    pim_dp
    #(
        .CAPTURE_BITS  (CAPTURE_BITS),
        .OVERFLOW_BITS (OVERFLOW_BITS)
    )
    u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .opcode            (opcode),
        .capture_value     (capture_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .duty_percent      (duty_percent),
        .frequency_hz      (frequency_hz),
        .measurement_count (measurement_count)
    );

endmodule

`default_nettype wire

### src/pim_div.sv
// pim_div: iterative restoring divider, one quotient bit per cycle
// depends on pim_pkg
`default_nettype none

module pim_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pim_pkg::STEP_W-1:0]   steps,
    input  wire logic [pim_pkg::WORD_W-1:0]   rem_init,
    input  wire logic [pim_pkg::WORD_W-1:0]   dividend,
    input  wire logic [pim_pkg::WORD_W-1:0]   divisor,
    output      logic                         busy,
    output      logic [pim_pkg::WORD_W-1:0]   quotient
);
    import pim_pkg::*;

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W+1:0] diff;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    // trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rem_reg, quo_reg[WORD_W-1]} - {2'b00, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = steps;
            rem_next = rem_init;
            quo_next = dividend;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (diff[WORD_W+1])
            begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
            end
            else
            begin
                rem_next = diff[WORD_W-1:0];
            end
            quo_next = {quo_reg[WORD_W-2:0], ~diff[WORD_W+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

### src/pim_dp.sv
// pim_dp: measurement state, tick assembly, duty/frequency arithmetic, output register
// depends on pim_pkg and pim_div
`default_nettype none

module pim_dp
#(
    parameter int unsigned CAPTURE_BITS  = 16,
    parameter int unsigned OVERFLOW_BITS = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pim_pkg::pim_cmd_t              cmd,
    output      pim_pkg::pim_status_t           status,
    input  wire logic                           cfg_write_en,
    input  wire logic [pim_pkg::WORD_W-1:0]     cfg_write_data,
    input  wire pim_pkg::opcode_t               opcode,
    input  wire logic [pim_pkg::CAP_IN_W-1:0]   capture_value,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic [pim_pkg::DUTY_W-1:0]     duty_percent,
    output      logic [pim_pkg::WORD_W-1:0]     frequency_hz,
    output      logic [pim_pkg::WORD_W-1:0]     measurement_count
);
    import pim_pkg::*;

    localparam int unsigned TICK_W = OVERFLOW_BITS + CAPTURE_BITS;
    localparam int unsigned WIDE_W = 2 * WORD_W;

    logic [OVERFLOW_BITS-1:0] ovf_reg, ovf_next;
    logic [WORD_W-1:0]        period_reg, period_next;
    logic [WORD_W-1:0]        high_reg, high_next;
    logic [WORD_W-1:0]        count_reg, count_next;
    logic [WORD_W-1:0]        clock_reg;
    logic                     emit_reg, emit_next;
    logic                     out_valid_reg, out_valid_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [DUTY_W-1:0]        duty_reg;
    logic [DUTY_W-1:0]        duty_out_reg;
    logic [WORD_W-1:0]        freq_out_reg;

    logic [WORD_W-1:0]        cap_ext;
    logic [CAPTURE_BITS-1:0]  cap_field;
    logic [TICK_W-1:0]        ticks_wide;
    logic [WIDE_W-1:0]        ticks_ext;
    logic [WORD_W-1:0]        ticks;

    logic                     div_start;
    logic [STEP_W-1:0]        div_steps;
    logic [WORD_W-1:0]        div_rem_init;
    logic [WORD_W-1:0]        div_dividend;
    logic                     div_busy;
    logic [WORD_W-1:0]        div_quo;

    // overflows above the capture field, saturated to 32 bits
    assign cap_ext    = WORD_W'(capture_value);
    assign cap_field  = cap_ext[CAPTURE_BITS-1:0];
    assign ticks_wide = {ovf_reg, cap_field};
    assign ticks_ext  = WIDE_W'(ticks_wide);
    assign ticks      = (|ticks_ext[WIDE_W-1:WORD_W]) ? TICK_MAX : ticks_ext[WORD_W-1:0];

    always_comb
    begin
        ovf_next    = ovf_reg;
        period_next = period_reg;
        high_next   = high_reg;
        emit_next   = emit_reg;
        if (cmd.capture)
        begin
            emit_next = 1'b1;
            case (opcode)
                OP_OVERFLOW: ovf_next = ovf_reg + 1'b1;
                OP_RISE:
                begin
                    period_next = ticks;
                    ovf_next    = '0;
                end
                OP_FALL:     high_next = ticks;
                default:     emit_next = 1'b0;
            endcase
            if (period_next == '0)
            begin
                emit_next = 1'b0;
            end
        end
    end

    // shared divider: duty runs 7 steps on the top of high*100, frequency 32 steps
    assign div_start    = cmd.start_duty | cmd.start_freq;
    assign div_steps    = cmd.start_duty ? STEPS_DUTY : STEPS_FREQ;
    assign div_rem_init = cmd.start_duty ? prod_reg[PROD_W-1:DUTY_W] : '0;
    assign div_dividend = cmd.start_duty ? {prod_reg[DUTY_W-1:0], {(WORD_W-DUTY_W){1'b0}}}
                                         : clock_reg;

    pim_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign status.emit     = emit_reg;
    assign status.clamp    = (high_reg >= period_reg);
    assign status.div_busy = div_busy;
    assign status.out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            count_next     = count_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg       <= '0;
            period_reg    <= '0;
            high_reg      <= '0;
            count_reg     <= '0;
            clock_reg     <= CLOCK_HZ_RESET;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ovf_reg       <= ovf_next;
            period_reg    <= period_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                clock_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            prod_reg <= PROD_W'(high_reg) * PROD_W'(DUTY_FULL);
        end
        if (cmd.save_duty)
        begin
            duty_reg <= status.clamp ? DUTY_FULL : div_quo[DUTY_W-1:0];
        end
        if (cmd.load_out)
        begin
            duty_out_reg <= duty_reg;
            freq_out_reg <= div_quo;
        end
    end

    assign out_valid         = out_valid_reg;
    assign duty_percent      = duty_out_reg;
    assign frequency_hz      = freq_out_reg;
    assign measurement_count = count_reg;

endmodule

`default_nettype wire

### src/pim_ctrl.sv
// pim_ctrl: sequencer for event capture, the two divisions and the result hand-off
// depends on pim_pkg
`default_nettype none

module pim_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire pim_pkg::pim_status_t  status,
    output      pim_pkg::pim_cmd_t     cmd
);
    import pim_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_CHECK      = 3'd1;
    localparam logic [2:0] S_DUTY_START = 3'd2;
    localparam logic [2:0] S_DUTY_WAIT  = 3'd3;
    localparam logic [2:0] S_FREQ_START = 3'd4;
    localparam logic [2:0] S_FREQ_WAIT  = 3'd5;
    localparam logic [2:0] S_OUTPUT     = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.emit)
                begin
                    state_next = S_IDLE;
                end
                else if (status.clamp)
                begin
                    cmd.save_duty = 1'b1;
                    state_next    = S_FREQ_START;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_DUTY_START;
                end
            end
            S_DUTY_START:
            begin
                cmd.start_duty = 1'b1;
                state_next     = S_DUTY_WAIT;
            end
            S_DUTY_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.save_duty = 1'b1;
                    state_next    = S_FREQ_START;
                end
            end
            S_FREQ_START:
            begin
                cmd.start_freq = 1'b1;
                state_next     = S_FREQ_WAIT;
            end
            S_FREQ_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### tb/pwm_input_capture_meter_tb.sv
// pwm_input_capture_meter_tb: self-checking bench for the pwm input capture meter
// needs pim_pkg and pwm_input_capture_meter; an event-level predictor runs in a
// scoreboard class while a bursty sender task and a stalling receiver process drive the block
`timescale 1ns / 1ps

import pim_pkg::*;

// predictor settings, kept equal to the parameters given to the instance
localparam int unsigned CAP_BITS = 16;
localparam int unsigned OVF_BITS = 16;
localparam int unsigned PERCENT  = 100;

typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [WORD_W-1:0] freq;
    logic [WORD_W-1:0] count;
} reading_t;

// tracks period, high time and overflows per accepted event, queues the readings
class meter_ledger;
    logic [WORD_W-1:0]   clock_hz;
    logic [OVF_BITS-1:0] overflows;
    logic [WORD_W-1:0]   period_ticks;
    logic [WORD_W-1:0]   high_ticks;
    logic [WORD_W-1:0]   emitted;
    reading_t            pending_readings[$];
    int                  errors;

    function new();
        clock_hz     = CLOCK_HZ_RESET;
        overflows    = '0;
        period_ticks = '0;
        high_ticks   = '0;
        emitted      = '0;
        errors       = 0;
    endfunction

    function void set_clock(input logic [WORD_W-1:0] hz);
        clock_hz = hz;
    endfunction

    function int outstanding();
        return pending_readings.size();
    endfunction

    // overflow turns above the capture bits, saturating at 32 bits
    function logic [WORD_W-1:0] span_ticks(input logic [CAP_IN_W-1:0] cap);
        logic [63:0] ovf_wide;
        logic [63:0] cap_wide;
        logic [63:0] whole;
        ovf_wide = 64'(overflows);
        cap_wide = 64'(cap);
        if (CAP_BITS < 64)
            cap_wide = cap_wide & ((64'd1 << CAP_BITS) - 64'd1);
        whole = (ovf_wide << CAP_BITS) + cap_wide;
        if (whole > {32'b0, TICK_MAX})
            return TICK_MAX;
        return whole[WORD_W-1:0];
    endfunction

    function void note_event(input opcode_t op, input logic [CAP_IN_W-1:0] cap);
        logic [63:0] ratio;
        reading_t    r;
        case (op)
            OP_OVERFLOW: overflows = overflows + 1'b1;
            OP_RISE:
            begin
                period_ticks = span_ticks(cap);
                overflows    = '0;
            end
            OP_FALL: high_ticks = span_ticks(cap);
            default: return;
        endcase
        if (period_ticks == '0)
            return;
        ratio = ({32'b0, high_ticks} * PERCENT) / {32'b0, period_ticks};
        if (ratio > DUTY_FULL)
            ratio = 64'(DUTY_FULL);
        emitted = emitted + 1'b1;
        r.duty  = ratio[DUTY_W-1:0];
        r.freq  = clock_hz / period_ticks;
        r.count = emitted;
        pending_readings.push_back(r);
    endfunction

    function void check_reading(input reading_t got);
        reading_t want;
        if (pending_readings.size() == 0)
        begin
            errors++;
            $display("%0t: reading with none expected: duty %0d freq %0d count %0d",
                     $time, got.duty, got.freq, got.count);
            return;
        end
        want = pending_readings.pop_front();
        if (got.duty !== want.duty)
        begin
            errors++;
            $display("%0t: duty_percent expected %0d got %0d", $time, want.duty, got.duty);
        end
        if (got.freq !== want.freq)
        begin
            errors++;
            $display("%0t: frequency_hz expected %0d got %0d", $time, want.freq, got.freq);
        end
        if (got.count !== want.count)
        begin
            errors++;
            $display("%0t: measurement_count expected %0d got %0d",
                     $time, want.count, got.count);
        end
    endfunction
endclass

module pwm_input_capture_meter_tb;

    localparam opcode_t     OP_UNUSED        = 2'd3;
    localparam int unsigned RANDOM_PER_PHASE = 220;
    // settle time after the readings are back, to cover the last one in flight
    localparam int unsigned SETTLE_CYCLES    = 64;
    // receiver hold-off, long enough to back the block up into its input
    localparam int unsigned HOLD_CYCLES      = 400;
    localparam longint unsigned LIMIT_NS     = 10_000_000;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_COMB, STALL_RARE} stall_mode_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_write_en   = 1'b0;
    logic [WORD_W-1:0]     cfg_write_data = '0;
    logic                  in_valid       = 1'b0;
    opcode_t               opcode         = OP_OVERFLOW;
    logic [CAP_IN_W-1:0]   capture_value  = '0;
    logic                  out_stall      = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [DUTY_W-1:0]     duty_percent;
    logic [WORD_W-1:0]     frequency_hz;
    logic [WORD_W-1:0]     measurement_count;

    meter_ledger ledger;
    int          burst_left = 0;
    bit          hold_req   = 1'b0;

    pwm_input_capture_meter
    #(
        .CAPTURE_BITS  (CAP_BITS),
        .OVERFLOW_BITS (OVF_BITS)
    )
    dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .capture_value     (capture_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .duty_percent      (duty_percent),
        .frequency_hz      (frequency_hz),
        .measurement_count (measurement_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(LIMIT_NS);
        $display("pwm_input_capture_meter_tb: done, errors");
        $finish;
    end

    // both channels sampled at the edge, before any nonblocking update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
                ledger.note_event(opcode, capture_value);
            if (out_valid === 1'b1 && !out_stall)
                ledger.check_reading({duty_percent, frequency_hz, measurement_count});
        end
    end

    // receiver: stall pattern switches between modes, plus one-off long hold-offs
    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
                    STALL_COMB: out_stall <= (mode_left % 5) < 2;
                    default:    out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // edge values show up often so the saturating corners get hit
    function automatic logic [CAP_IN_W-1:0] pick_capture();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CAP_IN_W'($urandom());
        endcase
    endfunction

    // one event transaction; bursts of random length with random gaps between them
    task automatic offer_event(input opcode_t op, input logic [CAP_IN_W-1:0] cap);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 8);
                default: gap = $urandom_range(9, 40);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        capture_value <= cap;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
    endtask

    // wait until every reading is back and the block has gone quiet
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clock(input logic [WORD_W-1:0] hz);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= hz;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        ledger.set_clock(hz);
    endtask

    task automatic directed_events();
        offer_event(OP_UNUSED, 16'hFFFF);     // ignored right out of reset
        offer_event(OP_FALL, 16'hFFFF);       // high time but no period yet
        offer_event(OP_RISE, 16'h0000);       // zero period, still silent
        offer_event(OP_RISE, 16'h0000);       // overflows cleared, zero period again
        offer_event(OP_OVERFLOW, 16'hFFFF);   // capture ignored on overflow
        offer_event(OP_RISE, 16'h0000);       // one full counter turn
        offer_event(OP_FALL, 16'h0000);       // zero duty
        offer_event(OP_UNUSED, 16'h0000);     // unused code with a live period
        offer_event(OP_RISE, 16'h0001);       // one-tick period, frequency equals clock
        offer_event(OP_FALL, 16'hFFFF);       // high time above period clamps
        offer_event(OP_OVERFLOW, 16'h5555);
        offer_event(OP_FALL, 16'hAAAA);
        offer_event(OP_RISE, 16'hFFFF);
        offer_event(OP_FALL, 16'h8000);
        repeat (3) offer_event(OP_OVERFLOW, 16'h0000);
        offer_event(OP_FALL, 16'h7FFF);
        offer_event(OP_OVERFLOW, 16'hFFFF);
        offer_event(OP_RISE, 16'h1234);
    endtask

    // one pwm period: overflows, falling edge inside (skipped now and then), more overflows, rising edge
    task automatic offer_pwm_cycle(inout int counted);
        int turns;
        int high_turns;
        bit skip_fall;
        turns      = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        high_turns = $urandom_range(0, turns);
        skip_fall  = ($urandom_range(0, 7) == 0);
        repeat (high_turns) offer_event(OP_OVERFLOW, pick_capture());
        if (!skip_fall)
        begin
            offer_event(OP_FALL, pick_capture());
            counted++;
        end
        repeat (turns - high_turns) offer_event(OP_OVERFLOW, pick_capture());
        offer_event(OP_RISE, pick_capture());
        counted += turns + 1;
    endtask

    // any code in any order, the unused one included
    task automatic offer_noise(inout int counted);
        int      n;
        opcode_t op;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            op = opcode_t'($urandom_range(0, 3));
            offer_event(op, pick_capture());
            if (op != OP_UNUSED)
                counted++;
        end
    endtask

    task automatic run_random(input int n);
        int counted;
        counted = 0;
        while (counted < n)
        begin
            if ($urandom_range(0, 9) < 7)
                offer_pwm_cycle(counted);
            else
                offer_noise(counted);
        end
    endtask

    initial
    begin : stimulus
        logic [WORD_W-1:0] clocks [4];
        ledger    = new();
        clocks[0] = 32'd1;
        clocks[1] = TICK_MAX;
        clocks[2] = $urandom_range(2, 32'hFFFF_FFFE);
        clocks[3] = CLOCK_HZ_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default clock first, then each register setting in turn
        directed_events();
        run_random(RANDOM_PER_PHASE);
        for (int p = 0; p < 4; p++)
        begin
            write_clock(clocks[p]);
            if (p == 1 || p == 3)
                hold_req = 1'b1;
            run_random(RANDOM_PER_PHASE);
        end

        drain();
        if (ledger.errors == 0)
            $display("pwm_input_capture_meter_tb: done, clean");
        else
            $display("pwm_input_capture_meter_tb: done, errors");
        $finish;
    end

endmodule

### pwm_input_capture_meter.f
src/pim_pkg.sv
src/pim_div.sv
src/pim_dp.sv
src/pim_ctrl.sv
src/pwm_input_capture_meter.sv
tb/pwm_input_capture_meter_tb.sv
